// ===== hw/rtl/ufsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufsr_pkg
// Shared types and codes of the UDP flow split replicator.
// ----------------------------------------------------------------------------
package ufsr_pkg;

  typedef enum logic [1:0] {
    FUNC_PACKET = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ACT_PASS = 3'd0,
    ACT_COPY = 3'd1,
    ACT_DROP = 3'd2,
    ACT_OK   = 3'd3,
    ACT_FAIL = 3'd4
  } action_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  in_queue;
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [7:0]  dqueue;
    logic        header_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] out_ip;
    logic [15:0] out_port;
    logic [7:0]  out_queue;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  queue;
  } dest_t;

  typedef struct packed {
    logic [7:0]  queue;
    logic [31:0] ip;
    logic [15:0] port;
  } key_t;

endpackage

// ===== hw/rtl/ufsr_stream_if.sv =====
// ----------------------------------------------------------------------------
// ufsr_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ufsr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/udp_flow_split_replicator.sv =====
// ----------------------------------------------------------------------------
// udp_flow_split_replicator
// Flow table with per-flow newest-first destination lists and replication.
// ----------------------------------------------------------------------------
// Key search reads one key a cycle over all NUM_FLOWS slots. The module takes
// one transaction at a time and accepts no request until its response or last
// copy is issued. Add and delete shift the list one entry at a time, a read
// state then a write state per entry. Output stalls hold the dispatch, copy
// and response states.
// Reset: valid bits and counts clear at once; key and list memories are
// left undefined and are only read under a valid flow and count.
module udp_flow_split_replicator
  import ufsr_pkg::*;
#(
  parameter int NUM_FLOWS      = 16,
  parameter int DESTS_PER_FLOW = 8,
  parameter int NUM_QUEUES     = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  ufsr_stream_if.sink   req_i,
  ufsr_stream_if.source rsp_o
);
  localparam int FW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int DW = (DESTS_PER_FLOW > 1) ? $clog2(DESTS_PER_FLOW) : 1;
  localparam int CW = $clog2(DESTS_PER_FLOW + 1);
  localparam int SW = $clog2(NUM_FLOWS + 1);
  localparam int AW = FW + DW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_DISP = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;
  localparam logic [2:0] S_DEL  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  key_t  key_mem [NUM_FLOWS];
  dest_t dst_mem [NUM_FLOWS*DESTS_PER_FLOW];

  logic [NUM_FLOWS-1:0] valid_q, valid_d;
  logic [CW-1:0]        cnt_q [NUM_FLOWS];

  logic [2:0]    st_q, st_d;
  req_t          r_q, r_d;
  logic [SW-1:0] sidx_q, sidx_d;
  logic          hit_q, hit_d;
  logic [FW-1:0] flow_q, flow_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  rsp_t          out_q, out_d;
  logic          ov_q, ov_d;

  key_t  key_rd_q;
  dest_t dst_rd_q;
  logic  krd_v_q, krd_v_d;
  logic [FW-1:0] krd_i_q, krd_i_d;

  logic          key_we;
  logic [FW-1:0] key_ra;
  logic          dst_we;
  logic [AW-1:0] dst_wa, dst_ra;
  dest_t         dst_wd;
  logic          cnt_we;
  logic [FW-1:0] cnt_wa;
  logic [CW-1:0] cnt_wd;

  logic          out_free;
  logic          q_ok;
  logic [CW-1:0] cnt_f;

  logic          free_any;
  logic [FW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_FLOWS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = FW'(i);
      end
    end
  end

  function automatic logic [AW-1:0] addr(logic [FW-1:0] f, logic [CW-1:0] i);
    return AW'(f) * AW'(DESTS_PER_FLOW) + AW'(i);
  endfunction

  logic key_match;
  assign key_match = krd_v_q && valid_q[krd_i_q] &&
                     key_rd_q == {r_q.in_queue, r_q.src_ip, r_q.sport};

  assign out_free = !ov_q || rsp_o.ready;
  assign q_ok     = {1'b0, r_q.dqueue} < 9'(NUM_QUEUES);
  assign cnt_f    = cnt_q[flow_q];
  assign key_ra   = sidx_q[FW-1:0];

  assign req_i.ready = (st_q == S_IDLE);
  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[free_idx] <= {r_q.in_queue, r_q.src_ip, r_q.sport};
    key_rd_q <= key_mem[key_ra];
    if (dst_we) dst_mem[dst_wa] <= dst_wd;
    dst_rd_q <= dst_mem[dst_ra];
  end

  always_comb begin
    st_d    = st_q;
    r_d     = r_q;
    sidx_d  = sidx_q;
    hit_d   = hit_q;
    flow_d  = flow_q;
    idx_d   = idx_q;
    n_d     = n_q;
    out_d   = out_q;
    ov_d    = ov_q;
    krd_v_d = 1'b0;
    krd_i_d = krd_i_q;
    valid_d = valid_q;
    cnt_we  = 1'b0;
    cnt_wa  = flow_q;
    cnt_wd  = '0;
    key_we  = 1'b0;
    dst_we  = 1'b0;
    dst_wa  = addr(flow_q, idx_q);
    dst_wd  = dst_rd_q;
    dst_ra  = addr(flow_q, idx_q);
    if (ov_q && rsp_o.ready) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (req_i.valid) begin
          r_d    = req_i.data;
          sidx_d = '0;
          hit_d  = 1'b0;
          st_d   = S_SRCH;
        end
      end
      S_SRCH: begin
        if (key_match && !hit_q) begin
          hit_d  = 1'b1;
          flow_d = krd_i_q;
        end
        if (sidx_q < SW'(NUM_FLOWS)) begin
          krd_v_d = 1'b1;
          krd_i_d = sidx_q[FW-1:0];
          sidx_d  = sidx_q + SW'(1);
        end else if (!krd_v_q) begin
          st_d = S_DISP;
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_d      = '0;
          out_d.last = 1'b1;
          st_d       = S_RESP;
          n_d        = cnt_f;
          idx_d      = '0;
          case (func_e'(r_q.func))
            FUNC_PACKET: begin
              out_d.action = ACT_PASS;
              if (r_q.header_ok && hit_q) begin
                if (cnt_f == '0) out_d.action = ACT_DROP;
                else st_d = S_COPY;
              end
            end
            FUNC_ADD: begin
              out_d.action = ACT_FAIL;
              if (q_ok) begin
                if (hit_q) begin
                  if (cnt_f < CW'(DESTS_PER_FLOW)) begin
                    idx_d = cnt_f;
                    st_d  = (cnt_f == '0) ? S_SHWR : S_SHRD;
                  end
                end else if (free_any) begin
                  key_we            = 1'b1;
                  dst_we            = 1'b1;
                  dst_wa            = addr(free_idx, '0);
                  dst_wd            = {r_q.dst_ip, r_q.dst_port, r_q.dqueue};
                  valid_d[free_idx] = 1'b1;
                  cnt_we            = 1'b1;
                  cnt_wa            = free_idx;
                  cnt_wd            = CW'(1);
                  out_d.action      = ACT_OK;
                end
              end
            end
            FUNC_DELETE: begin
              out_d.action = ACT_FAIL;
              if (hit_q && cnt_f != '0) st_d = S_DEL;
            end
            default: begin
              out_d.action = ACT_FAIL;
              if (hit_q) begin
                valid_d[flow_q] = 1'b0;
                cnt_we          = 1'b1;
                cnt_wa          = flow_q;
                cnt_wd          = '0;
                out_d.action    = ACT_OK;
              end
            end
          endcase
        end
      end
      S_COPY: begin
        if (!out_free) begin
          // keep the pending entry in the read register
          dst_ra = addr(flow_q, idx_q - CW'(1));
        end else begin
          if (idx_q != '0) begin
            out_d.action    = ACT_COPY;
            out_d.out_ip    = dst_rd_q.ip;
            out_d.out_port  = dst_rd_q.port;
            out_d.out_queue = dst_rd_q.queue;
            out_d.last      = (idx_q == n_q);
            ov_d            = 1'b1;
            if (idx_q == n_q) st_d = S_IDLE;
          end
          if (idx_q != n_q) idx_d = idx_q + CW'(1);
        end
      end
      S_DEL: begin
        // read of entry idx_q is registered and seen in the next cycle
        if (idx_q != '0 && dst_rd_q.ip == r_q.dst_ip &&
            dst_rd_q.port == r_q.dst_port) begin
          st_d = S_SHRD;
        end else if (idx_q == n_q) begin
          st_d = S_RESP;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_SHRD: begin
        if (r_q.func == FUNC_ADD) dst_ra = addr(flow_q, idx_q - CW'(1));
        st_d = S_SHWR;
      end
      S_SHWR: begin
        dst_we = 1'b1;
        if (r_q.func == FUNC_ADD) begin
          dst_wa = addr(flow_q, idx_q);
          if (idx_q == '0) begin
            dst_wd       = {r_q.dst_ip, r_q.dst_port, r_q.dqueue};
            cnt_we       = 1'b1;
            cnt_wd       = n_q + CW'(1);
            out_d.action = ACT_OK;
            st_d         = S_RESP;
          end else begin
            idx_d = idx_q - CW'(1);
            st_d  = (idx_q == CW'(1)) ? S_SHWR : S_SHRD;
          end
        end else begin
          dst_wa = addr(flow_q, idx_q - CW'(1));
          if (idx_q == n_q) begin
            cnt_we       = 1'b1;
            cnt_wd       = n_q - CW'(1);
            out_d.action = ACT_OK;
            st_d         = S_RESP;
          end else begin
            idx_d = idx_q + CW'(1);
            st_d  = S_SHRD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      r_q     <= '0;
      valid_q <= '0;
      for (int i = 0; i < NUM_FLOWS; i++) cnt_q[i] <= '0;
      out_q   <= '0;
      ov_q    <= 1'b0;
      krd_v_q <= 1'b0;
      sidx_q  <= '0;
      hit_q   <= 1'b0;
      flow_q  <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      krd_i_q <= '0;
    end else begin
      st_q    <= st_d;
      r_q     <= r_d;
      valid_q <= valid_d;
      if (cnt_we) cnt_q[cnt_wa] <= cnt_wd;
      out_q   <= out_d;
      ov_q    <= ov_d;
      krd_v_q <= krd_v_d;
      sidx_q  <= sidx_d;
      hit_q   <= hit_d;
      flow_q  <= flow_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      krd_i_q <= krd_i_d;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> $stable(rsp_o.data))
    else $error("result changed while stalled");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("result dropped while stalled");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !req_i.ready)
    else $error("ready while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[flow_q] <= CW'(DESTS_PER_FLOW))
    else $error("destination count overflow");
`endif
endmodule
